// ===== rtl/kve_pkg.sv =====
// shared types and constants for the keyed line value extractor
package kve_pkg;

    localparam int KVE_MAX_KEY_BYTES = 16;
    localparam int KVE_QUEUE_DEPTH   = 4;
    localparam int KVE_ADDR_W        = 5;
    localparam int KVE_DATA_W        = 64;
    localparam int KVE_KEY_LEN_W     = 5;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;

    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_LINE,
        PH_SPACES,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [63:0]              key_high;
        logic [63:0]              key_low;
        logic [KVE_KEY_LEN_W-1:0] key_length;
    } key_cfg_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       has_value;
        logic       end_of_value;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

// ===== rtl/kve_cfg_regs.sv =====
// apb configuration registers holding the key and its length
module kve_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kve_pkg::KVE_ADDR_W-1:0]  paddr,
    input  logic [kve_pkg::KVE_DATA_W-1:0]  pwdata,
    output logic [kve_pkg::KVE_DATA_W-1:0]  prdata,
    output logic                            pready,
    output kve_pkg::key_cfg_t               key_cfg
);
    import kve_pkg::*;

    logic [63:0]              key_low_reg;
    logic [63:0]              key_high_reg;
    logic [KVE_KEY_LEN_W-1:0] key_len_reg;
    logic [1:0]               reg_index;
    logic                     wr_en;

    assign reg_index = paddr[4:3];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_KEY_LEN:  key_len_reg  <= pwdata[KVE_KEY_LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LEN:  prdata = {{(KVE_DATA_W-KVE_KEY_LEN_W){1'b0}}, key_len_reg};
            default:      prdata = '0;
        endcase
    end

    assign key_cfg.key_low    = key_low_reg;
    assign key_cfg.key_high   = key_high_reg;
    assign key_cfg.key_length = key_len_reg;

endmodule

// ===== rtl/kve_parser.sv =====
// per-byte line parser: key match, colon, space skip and value emission
module kve_parser
#(
    parameter int MAX_KEY_BYTES = kve_pkg::KVE_MAX_KEY_BYTES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    input  logic                    final_byte,
    input  kve_pkg::key_cfg_t       key_cfg,
    output kve_pkg::result_pair_t   results
);
    import kve_pkg::*;

    localparam int POS_W = $clog2(MAX_KEY_BYTES + 1);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [7:0]        held_reg;
    logic [7:0]        held_next;

    logic [127:0]      key_vec;
    logic [7:0]        key_byte;
    logic [POS_W-1:0]  klen;
    logic              is_lf;
    logic              is_eol;
    logic              is_blank;

    assign key_vec  = {key_cfg.key_high, key_cfg.key_low};
    assign key_byte = key_vec[8*(4'(pos_reg)) +: 8];
    assign klen     = (key_cfg.key_length > KVE_KEY_LEN_W'(MAX_KEY_BYTES))
                      ? POS_W'(MAX_KEY_BYTES) : POS_W'(key_cfg.key_length);
    assign is_lf    = (data_byte == CHAR_LF);
    assign is_eol   = (data_byte == CHAR_CR) || is_lf;
    assign is_blank = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_KEY:
            begin
                if (pos_reg >= klen)
                begin
                    pos_next = '0;
                    if (data_byte == CHAR_COLON)
                        phase_next = PH_SPACES;
                    else
                        phase_next = is_lf ? PH_KEY : PH_LINE;
                end
                else if (data_byte == key_byte)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    pos_next   = '0;
                    phase_next = is_lf ? PH_KEY : PH_LINE;
                end
            end
            PH_LINE:
            begin
                if (is_lf)
                    phase_next = PH_KEY;
            end
            PH_SPACES:
            begin
                if (!is_blank)
                begin
                    held_next  = data_byte;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (is_eol)
                    phase_next = PH_DONE;
                else
                    held_next = data_byte;
            end
            PH_DONE:    ;
            default:    phase_next = PH_KEY;
        endcase
        if (final_byte)
        begin
            phase_next = PH_KEY;
            pos_next   = '0;
            held_next  = '0;
        end
    end

    always_comb
    begin
        results = '0;
        unique case (phase_reg)
            PH_SPACES:
            begin
                if (final_byte)
                begin
                    results.count = 2'd1;
                    results.first = is_blank ? result_t'{8'h00, 1'b0, 1'b1}
                                             : result_t'{data_byte, 1'b1, 1'b1};
                end
            end
            PH_DATA:
            begin
                if (is_eol)
                begin
                    results.count = 2'd1;
                    results.first = result_t'{held_reg, 1'b1, 1'b1};
                end
                else
                begin
                    results.count  = final_byte ? 2'd2 : 2'd1;
                    results.first  = result_t'{held_reg, 1'b1, 1'b0};
                    results.second = result_t'{data_byte, 1'b1, 1'b1};
                end
            end
            PH_DONE:    ;
            default:
            begin
                if (final_byte)
                begin
                    results.count = 2'd1;
                    results.first = result_t'{8'h00, 1'b0, 1'b1};
                end
            end
        endcase
        if (!accept)
            results.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY;
            pos_reg   <= '0;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== rtl/kve_out_queue.sv =====
// queue takes up to two results per cycle, sends one if out_ready
module kve_out_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  kve_pkg::result_pair_t   results,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output kve_pkg::result_t        out_result
);
    import kve_pkg::*;

    localparam int PTR_W = $clog2(KVE_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(KVE_QUEUE_DEPTH + 1);

    result_t            entry_reg [KVE_QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               pop;

    assign out_valid  = (cnt_reg != '0);
    assign out_result = entry_reg[rd_ptr_reg];
    assign room       = (cnt_reg <= CNT_W'(KVE_QUEUE_DEPTH - 2));
    assign pop        = out_valid & out_ready;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(results.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign cnt_next    = cnt_reg + CNT_W'(results.count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (results.count != 2'd0)
            entry_reg[wr_ptr_reg] <= results.first;
        if (results.count == 2'd2)
            entry_reg[wr_ptr_reg + 1'b1] <= results.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/keyed_line_value_extractor_unit.sv =====
// results enter the result queue on their input transfer and leave on m_tvalid in order
// throughput: one input byte per cycle while s_tready is high; a byte with two results
// sends them in turn; the four-entry result queue holds input while three or more results wait
// reset: rst_n clears parser state, queue and key registers at once, no clearing pass
// top level of the keyed line value extractor
module keyed_line_value_extractor_unit
#(
    parameter int MAX_KEY_BYTES = kve_pkg::KVE_MAX_KEY_BYTES
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // data_byte
    input  logic                            s_tlast,   // final_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // value_byte
    output logic                            m_tuser,   // has_value
    output logic                            m_tlast,   // end_of_value
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kve_pkg::KVE_ADDR_W-1:0]  paddr,
    input  logic [kve_pkg::KVE_DATA_W-1:0]  pwdata,
    output logic [kve_pkg::KVE_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import kve_pkg::*;

    key_cfg_t      key_cfg;
    result_pair_t  results;
    result_t       out_result;
    logic          accept;

    assign accept = s_tvalid & s_tready;

    kve_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key_cfg (key_cfg)
    );

    kve_parser
    #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    )
    u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .key_cfg    (key_cfg),
        .results    (results)
    );

    kve_out_queue u_out_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .results    (results),
        .room       (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = out_result.value_byte;
    assign m_tuser = out_result.has_value;
    assign m_tlast = out_result.end_of_value;

endmodule

// ===== rtl/kve_checker.sv =====
// port-level checks for the keyed line value extractor, bound to the top level
module kve_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tready,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser,
    input  logic       m_tlast
);

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // empty result is zero and closes the text
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'h00))
        else $error("malformed empty result");

    // input is only held back by pending results
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

endmodule

bind keyed_line_value_extractor_unit kve_checker u_kve_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/testbench.sv =====
// directed and random byte-stream test of the keyed line value extractor against its own predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kve_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 100;

    localparam result_t R_NONE  = '0;
    localparam result_t R_EMPTY = {8'h00, 1'b0, 1'b1};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] typed_n;
        result_t    t0;
        result_t    t1;
    } dir_row_t;

    // typed rows carry their results, the rest go through the predictor
    localparam dir_row_t DIRECTED_ROWS [24] = '{
        {8'h00, 1'b1, 1'b1, 2'd1, R_EMPTY, R_NONE},
        {8'hff, 1'b1, 1'b1, 2'd1, R_EMPTY, R_NONE},
        {CHAR_COLON, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {CHAR_SPACE, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {CHAR_TAB, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {8'h41, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {8'hff, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {CHAR_CR, 1'b0, 1'b1, 2'd1, {8'hff, 1'b1, 1'b1}, R_NONE},
        {8'h7a, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {8'h71, 1'b1, 1'b1, 2'd0, R_NONE, R_NONE},
        {CHAR_COLON, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {CHAR_CR, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {8'h78, 1'b1, 1'b1, 2'd2, {CHAR_CR, 1'b1, 1'b0}, {8'h78, 1'b1, 1'b1}},
        {8'h61, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {CHAR_LF, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {CHAR_LF, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {CHAR_COLON, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {CHAR_SPACE, 1'b1, 1'b1, 2'd1, R_EMPTY, R_NONE},
        {CHAR_COLON, 1'b1, 1'b1, 2'd1, R_EMPTY, R_NONE},
        {CHAR_COLON, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {8'h00, 1'b1, 1'b1, 2'd1, {8'h00, 1'b1, 1'b1}, R_NONE},
        {CHAR_COLON, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {8'h62, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
        {CHAR_LF, 1'b1, 1'b0, 2'd0, R_NONE, R_NONE}
    };

    localparam int PHASE_KEY_LEN [PHASE_COUNT] = '{0, 1, 3, 8, 9, 16, 31, 17, 12, 5};

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // data_byte
    logic                  s_tlast;    // final_byte
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;    // value_byte
    logic                  m_tuser;    // has_value
    logic                  m_tlast;    // end_of_value
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [KVE_ADDR_W-1:0] paddr;
    logic [KVE_DATA_W-1:0] pwdata;
    logic [KVE_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor copy of the registers and parser state
    logic [63:0]           cfg_key_low;
    logic [63:0]           cfg_key_high;
    logic [4:0]            cfg_key_len;
    phase_t                scan_phase;
    int                    key_pos;
    logic [7:0]            held_char;
    result_t               step_out [2];

    result_t               expected_values [$];
    logic [7:0]            text_q [$];

    // typed expectations of the item currently offered
    logic                  cur_typed;
    int                    cur_typed_n;
    result_t               cur_t0;
    result_t               cur_t1;

    int                    send_idle_pct;
    int                    stall_pct;
    int                    mismatches;
    int                    cycle_count = 0;
    int                    step_n;
    result_t               got_value;
    result_t               want_value;

    keyed_line_value_extractor_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function int eff_key_len();
        return (cfg_key_len > KVE_MAX_KEY_BYTES) ? KVE_MAX_KEY_BYTES : int'(cfg_key_len);
    endfunction

    function logic [7:0] key_char(input int pos);
        if (pos < 8)
            return cfg_key_low[pos*8 +: 8];
        return cfg_key_high[(pos-8)*8 +: 8];
    endfunction

    function result_t make_result(input logic [7:0] v, input logic h, input logic e);
        return {v, h, e};
    endfunction

    // advances the parser by one byte, fills step_out and returns the result count
    function int extract_step(input logic [7:0] b, input logic fin);
        int   n;
        logic ended;
        int   klen;
        n = 0;
        ended = 1'b0;
        klen = eff_key_len();
        step_out[0] = R_NONE;
        step_out[1] = R_NONE;
        case (scan_phase)
            PH_LINE:
            begin
                if (b == CHAR_LF)
                begin
                    scan_phase = PH_KEY;
                    key_pos = 0;
                end
            end
            PH_SPACES:
            begin
                if (b != CHAR_SPACE && b != CHAR_TAB)
                begin
                    held_char = b;
                    scan_phase = PH_DATA;
                    if (fin)
                    begin
                        step_out[n] = make_result(b, 1'b1, 1'b1);
                        n++;
                        ended = 1'b1;
                    end
                end
            end
            PH_DATA:
            begin
                if (b == CHAR_CR || b == CHAR_LF)
                begin
                    step_out[n] = make_result(held_char, 1'b1, 1'b1);
                    n++;
                    ended = 1'b1;
                    scan_phase = PH_DONE;
                end
                else
                begin
                    step_out[n] = make_result(held_char, 1'b1, 1'b0);
                    n++;
                    held_char = b;
                    if (fin)
                    begin
                        step_out[n] = make_result(b, 1'b1, 1'b1);
                        n++;
                        ended = 1'b1;
                    end
                end
            end
            PH_DONE:
                ended = 1'b1;
            default:
            begin
                if (key_pos >= klen)
                begin
                    key_pos = 0;
                    if (b == CHAR_COLON)
                        scan_phase = PH_SPACES;
                    else
                        scan_phase = (b == CHAR_LF) ? PH_KEY : PH_LINE;
                end
                else if (b == key_char(key_pos))
                    key_pos++;
                else
                begin
                    key_pos = 0;
                    scan_phase = (b == CHAR_LF) ? PH_KEY : PH_LINE;
                end
            end
        endcase
        if (fin)
        begin
            if (!ended)
            begin
                step_out[n] = R_EMPTY;
                n++;
            end
            scan_phase = PH_KEY;
            key_pos = 0;
            held_char = 8'h00;
        end
        return n;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL keyed_line_value_extractor_unit");
            $finish;
        end
    end

    // input transfers feed the predictor, output transfers are checked in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                step_n = extract_step(s_tdata, s_tlast);
                if (cur_typed)
                begin
                    if (cur_typed_n > 0)
                        expected_values.push_back(cur_t0);
                    if (cur_typed_n > 1)
                        expected_values.push_back(cur_t1);
                end
                else
                begin
                    for (int k = 0; k < step_n; k++)
                        expected_values.push_back(step_out[k]);
                end
            end
            if (m_tvalid && m_tready)
            begin
                got_value = {m_tdata, m_tuser, m_tlast};
                if (expected_values.size() == 0)
                    note_mismatch($sformatf("result with nothing expected: byte %h value %b end %b",
                        m_tdata, m_tuser, m_tlast));
                else
                begin
                    want_value = expected_values.pop_front();
                    if (got_value.value_byte !== want_value.value_byte ||
                        got_value.has_value !== want_value.has_value ||
                        got_value.end_of_value !== want_value.end_of_value)
                        note_mismatch($sformatf(
                            "expected byte %h value %b end %b, got byte %h value %b end %b",
                            want_value.value_byte, want_value.has_value, want_value.end_of_value,
                            got_value.value_byte, got_value.has_value, got_value.end_of_value));
                end
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input int typed_n, input result_t t0, input result_t t1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= b;
        s_tlast     <= fin;
        cur_typed   <= typed;
        cur_typed_n <= typed_n;
        cur_t0      <= t0;
        cur_t1      <= t1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // write one key register, then read it back
    task automatic program_key_reg(input logic [1:0] idx, input logic [63:0] value);
        logic [63:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_KEY_LOW:  cfg_key_low = value;
            REG_KEY_HIGH: cfg_key_high = value;
            default:      cfg_key_len = value[4:0];
        endcase
        want = (idx == REG_KEY_LOW) ? cfg_key_low :
               (idx == REG_KEY_HIGH) ? cfg_key_high : {59'd0, cfg_key_len};
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
            note_mismatch($sformatf("register %0d read: expected %h, got %h", idx, want, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function logic [7:0] value_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return (c == CHAR_CR || c == CHAR_LF) ? 8'h76 : c;
    endfunction

    function logic [7:0] noise_char();
        return ($urandom_range(4) == 0) ? CHAR_LF : 8'($urandom_range(255));
    endfunction

    task automatic push_key(input int n);
        for (int k = 0; k < n; k++)
            text_q.push_back(key_char(k));
    endtask

    task automatic push_noise(input int max_n);
        int n;
        n = $urandom_range(max_n);
        repeat (n) text_q.push_back(noise_char());
    endtask

    // one text of a few lines, mostly shaped around the current key
    task automatic build_text();
        int lines;
        int kind;
        int n;
        int klen;
        int cut;
        text_q.delete();
        klen = eff_key_len();
        lines = $urandom_range(1, 4);
        for (int i = 0; i < lines; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                push_key(klen);
                text_q.push_back(CHAR_COLON);
                n = $urandom_range(3);
                repeat (n) text_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
                n = $urandom_range(6);
                repeat (n) text_q.push_back(value_char());
                case ($urandom_range(3))
                    0: text_q.push_back(CHAR_LF);
                    1:
                    begin
                        text_q.push_back(CHAR_CR);
                        text_q.push_back(CHAR_LF);
                    end
                    2: text_q.push_back(CHAR_CR);
                    default: ;
                endcase
            end
            else if (kind < 65)
            begin
                push_key($urandom_range(klen));
                text_q.push_back(noise_char());
                push_noise(5);
                text_q.push_back(CHAR_LF);
            end
            else if (kind < 75)
            begin
                push_key(klen);
                text_q.push_back($urandom_range(1) ? CHAR_LF : value_char());
                push_noise(5);
                text_q.push_back(CHAR_LF);
            end
            else if (kind < 85)
            begin
                text_q.push_back(CHAR_COLON);
                push_noise(6);
                text_q.push_back(CHAR_LF);
            end
            else
            begin
                push_noise(8);
                text_q.push_back(CHAR_LF);
            end
        end
        if (text_q.size() > 1 && $urandom_range(4) == 0)
        begin
            cut = $urandom_range(1, text_q.size());
            while (text_q.size() > cut)
                void'(text_q.pop_back());
        end
        if (text_q.size() == 0)
            text_q.push_back(8'($urandom_range(255)));
    endtask

    initial
    begin
        logic [127:0] key_buf;
        int           len;
        int           eff;
        int           phase_items;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_typed = 1'b0;
        cur_typed_n = 0;
        cur_t0 = R_NONE;
        cur_t1 = R_NONE;
        send_idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        cfg_key_low = '0;
        cfg_key_high = '0;
        cfg_key_len = '0;
        scan_phase = PH_KEY;
        key_pos = 0;
        held_char = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[r])
            send_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
                      int'(DIRECTED_ROWS[r].typed_n), DIRECTED_ROWS[r].t0, DIRECTED_ROWS[r].t1);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            send_idle_pct = 0;
            stall_pct = 0;
            len = PHASE_KEY_LEN[p];
            eff = (len > KVE_MAX_KEY_BYTES) ? KVE_MAX_KEY_BYTES : len;
            key_buf = {$urandom, $urandom, $urandom, $urandom};
            if (p == 5)
                key_buf = '1;
            else if (p == 6)
                key_buf = '0;
            else
            begin
                for (int k = 0; k < eff; k++)
                    key_buf[k*8 +: 8] = 8'($urandom_range(8'h21, 8'h7e));
                // newline inside the key
                if (p == 8)
                    key_buf[$urandom_range(eff - 1)*8 +: 8] = CHAR_LF;
            end
            program_key_reg(REG_KEY_LOW, key_buf[63:0]);
            program_key_reg(REG_KEY_HIGH, key_buf[127:64]);
            program_key_reg(REG_KEY_LEN, 64'(len));

            case (p % 4)
                1: send_idle_pct = 59;
                2: stall_pct = 59;
                3:
                begin
                    send_idle_pct = 9;
                    stall_pct = 9;
                end
                default: ;
            endcase

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                build_text();
                for (int i = 0; i < text_q.size(); i++)
                    send_byte(text_q[i], i == text_q.size() - 1, 1'b0, 0, R_NONE, R_NONE);
                phase_items += text_q.size();
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_values.size() == 0)
            $display("PASS keyed_line_value_extractor_unit");
        else
            $display("FAIL keyed_line_value_extractor_unit");
        $finish;
    end

endmodule
